/* sv/bcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants for the battery charge sequencer
// Holds the timing constants, phase and LED codes, register indexes and the
// packed beat types of the input and result channels.
// ----------------------------------------------------------------------------
package bcs_pkg;

  // Timing constants, in ticks.
  localparam logic [15:0] PRECHARGE_TICKS   = 16'd1024;
  localparam logic [15:0] FLOAT_TICKS       = 16'd32768;
  localparam logic [15:0] FLOAT_RELAX_TICKS = 16'd16384;
  localparam logic [7:0]  MIN_HOLD_TICKS    = 8'd16;
  localparam logic [15:0] FLAT_TICKS        = 16'd4096;

  // Significant bits of the ADC samples; the mask never exceeds 10 bits.
  localparam int          SENSE_BITS = 10;
  localparam logic [9:0]  SENSE_MASK = 10'(((1 << SENSE_BITS) - 1) & 'h3FF);

  // Charge phases.
  typedef enum logic [2:0] {
    PH_PRE    = 3'd0,
    PH_CHARGE = 3'd1,
    PH_FLOAT  = 3'd2,
    PH_DONE   = 3'd3,
    PH_IDLE   = 3'd4,
    PH_FAULT  = 3'd5
  } phase_t;

  // LED patterns.
  localparam logic [1:0] LED_OFF  = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;
  localparam logic [1:0] LED_SLOW = 2'd2;
  localparam logic [1:0] LED_FAST = 2'd3;

  // Setpoint selects.
  localparam logic [1:0] CUR_ZERO = 2'd0;
  localparam logic [1:0] CUR_PRE  = 2'd1;
  localparam logic [1:0] CUR_FULL = 2'd2;
  localparam logic [1:0] VOL_ZERO  = 2'd0;
  localparam logic [1:0] VOL_CHG   = 2'd1;
  localparam logic [1:0] VOL_FLOAT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_CUTOFF_V   = 3'd1;
  localparam logic [2:0] REG_FULL_I     = 3'd2;
  localparam logic [2:0] REG_STOP_I     = 3'd3;
  localparam logic [2:0] REG_PRESENCE_I = 3'd4;
  localparam logic [2:0] REG_TOPPING_V  = 3'd5;
  localparam logic [2:0] REG_PRESENCE_V = 3'd6;

  // Input beat.
  typedef struct packed {
    logic [9:0] battery_voltage;
    logic [9:0] charge_current;
    logic       in_cv_regulation;
    logic       restart;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] led_pattern;
    logic [1:0] current_select;
    logic [1:0] voltage_select;
    logic       converter_on;
  } out_beat_t;

endpackage
`default_nettype wire

/* sv/battery_charge_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat's result is registered in the output register, or in the
// skid entry of the two-entry result stage while a result waits. Throughput:
// one input beat per cycle while the skid entry is empty; the phase update is
// a single pass of compares and decrements between the state registers and
// the result stage. Reset (rst, synchronous) loads the configuration defaults
// and starts the charge in precharge; no result is pending after reset.
// ----------------------------------------------------------------------------
// battery_charge_sequencer: CC/CV battery charge phase controller
// Steps precharge, charge, float, done, idle and fault once per sample beat
// and reports the phase, LED pattern, setpoint selects and converter enable.
// ----------------------------------------------------------------------------
module battery_charge_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [9:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bcs_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bcs_pkg::out_beat_t      out_data
);
  import bcs_pkg::*;

  // Configuration registers.
  logic [1:0] mode_bits;
  logic [9:0] start_voltage, full_current_limit, stop_current;
  logic [9:0] presence_current, recharge_voltage, presence_voltage;

  // Charge state.
  phase_t     phase_reg, phase_reg_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [9:0] min_current, min_current_next;
  logic [7:0] min_hold_count, min_hold_count_next;
  logic [15:0] flat_count, flat_count_next;
  logic [1:0] led_reg, led_reg_next;
  logic [1:0] current_sel_reg, current_sel_reg_next;
  logic [1:0] voltage_sel_reg, voltage_sel_reg_next;
  logic       converter_reg, converter_reg_next;

  // Result stage with one skid entry.
  logic       skid_valid;
  out_beat_t  skid_data;
  out_beat_t  result;

  logic       accept, take;
  logic [9:0] vs, is, ilim;

  assign accept   = in_valid && in_ready;
  assign take     = out_valid && out_ready;
  assign in_ready = !skid_valid;

  assign vs   = in_data.battery_voltage & SENSE_MASK;
  assign is   = in_data.charge_current & SENSE_MASK;
  assign ilim = full_current_limit & SENSE_MASK;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits          <= 2'd0;
      start_voltage      <= 10'd0;
      full_current_limit <= 10'd1023;
      stop_current       <= 10'd0;
      presence_current   <= 10'd0;
      recharge_voltage   <= 10'd0;
      presence_voltage   <= 10'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:       mode_bits          <= cfg_data[1:0];
        REG_CUTOFF_V:   start_voltage      <= cfg_data;
        REG_FULL_I:     full_current_limit <= cfg_data;
        REG_STOP_I:     stop_current       <= cfg_data;
        REG_PRESENCE_I: presence_current   <= cfg_data;
        REG_TOPPING_V:  recharge_voltage   <= cfg_data;
        REG_PRESENCE_V: presence_voltage   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Next charge state for the beat on the input.
  always_comb begin
    phase_reg_next       = phase_reg;
    phase_timer_next     = phase_timer;
    min_current_next     = min_current;
    min_hold_count_next  = min_hold_count;
    flat_count_next      = flat_count;
    led_reg_next         = led_reg;
    current_sel_reg_next = current_sel_reg;
    voltage_sel_reg_next = voltage_sel_reg;
    converter_reg_next   = converter_reg;
    if (in_data.restart) begin
      phase_reg_next       = PH_PRE;
      phase_timer_next     = PRECHARGE_TICKS;
      led_reg_next         = LED_SLOW;
      current_sel_reg_next = CUR_PRE;
      voltage_sel_reg_next = VOL_CHG;
      min_current_next     = ilim;
      min_hold_count_next  = MIN_HOLD_TICKS;
      flat_count_next      = FLAT_TICKS;
      converter_reg_next   = 1'b1;
    end else begin
      case (phase_reg)
        PH_PRE: begin
          led_reg_next = LED_SLOW;
          if (vs < (start_voltage & SENSE_MASK)) begin
            if (phase_timer != 16'd0) phase_timer_next = phase_timer - 16'd1;
            else phase_reg_next = PH_FAULT;
          end else begin
            phase_reg_next       = PH_CHARGE;
            current_sel_reg_next = CUR_FULL;
          end
        end
        PH_CHARGE: begin
          led_reg_next = LED_SLOW;
          // Debounced minimum tracking while the converter holds CV.
          if (in_data.in_cv_regulation) begin
            if (is < min_current) begin
              if (min_hold_count != 8'd0) begin
                min_hold_count_next = min_hold_count - 8'd1;
              end else begin
                min_current_next    = is;
                min_hold_count_next = MIN_HOLD_TICKS;
                flat_count_next     = FLAT_TICKS;
              end
            end else begin
              min_hold_count_next = MIN_HOLD_TICKS;
              if (flat_count != 16'd0) flat_count_next = flat_count - 16'd1;
            end
          end else begin
            min_hold_count_next = MIN_HOLD_TICKS;
            flat_count_next     = FLAT_TICKS;
            min_current_next    = ilim;
          end
          // End of charge uses the freshly updated tracker values.
          if (min_current_next < (stop_current & SENSE_MASK) || flat_count_next == 16'd0)
          begin
            if (mode_bits[0]) begin
              phase_reg_next       = PH_FLOAT;
              phase_timer_next     = FLOAT_TICKS;
              voltage_sel_reg_next = VOL_FLOAT;
            end else if (min_current_next < (presence_current & SENSE_MASK)) begin
              phase_reg_next = PH_IDLE;
            end else begin
              phase_reg_next = PH_DONE;
            end
          end
        end
        PH_FLOAT: begin
          led_reg_next = LED_ON;
          if (phase_timer != 16'd0) phase_timer_next = phase_timer - 16'd1;
          else phase_reg_next = PH_DONE;
          // Early exit once the battery is removed during the relaxed part.
          if (mode_bits[0] && phase_timer_next < FLOAT_RELAX_TICKS &&
              is < (presence_current & SENSE_MASK)) begin
            phase_reg_next = PH_IDLE;
          end
        end
        PH_IDLE: begin
          led_reg_next         = LED_OFF;
          voltage_sel_reg_next = VOL_ZERO;
          current_sel_reg_next = CUR_ZERO;
          converter_reg_next   = 1'b0;
        end
        PH_FAULT: begin
          led_reg_next         = LED_FAST;
          voltage_sel_reg_next = VOL_ZERO;
          current_sel_reg_next = CUR_ZERO;
          converter_reg_next   = 1'b0;
        end
        PH_DONE: begin
          led_reg_next = LED_ON;
          if (mode_bits[1]) begin
            // Standby: recharge a connected battery that has sagged.
            if (vs < (recharge_voltage & SENSE_MASK) &&
                vs > (presence_voltage & SENSE_MASK)) begin
              phase_reg_next       = PH_CHARGE;
              current_sel_reg_next = CUR_FULL;
              voltage_sel_reg_next = VOL_CHG;
              min_current_next     = ilim;
              min_hold_count_next  = MIN_HOLD_TICKS;
              flat_count_next      = FLAT_TICKS;
              converter_reg_next   = 1'b1;
            end else begin
              voltage_sel_reg_next = VOL_ZERO;
              current_sel_reg_next = CUR_ZERO;
              converter_reg_next   = 1'b0;
              if (vs < (presence_voltage & SENSE_MASK)) phase_reg_next = PH_IDLE;
            end
          end else begin
            phase_reg_next = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= PH_PRE;
      phase_timer     <= PRECHARGE_TICKS;
      min_current     <= 10'd1023 & SENSE_MASK;
      min_hold_count  <= MIN_HOLD_TICKS;
      flat_count      <= FLAT_TICKS;
      led_reg         <= LED_SLOW;
      current_sel_reg <= CUR_PRE;
      voltage_sel_reg <= VOL_CHG;
      converter_reg   <= 1'b1;
    end else if (accept) begin
      phase_reg       <= phase_reg_next;
      phase_timer     <= phase_timer_next;
      min_current     <= min_current_next;
      min_hold_count  <= min_hold_count_next;
      flat_count      <= flat_count_next;
      led_reg         <= led_reg_next;
      current_sel_reg <= current_sel_reg_next;
      voltage_sel_reg <= voltage_sel_reg_next;
      converter_reg   <= converter_reg_next;
    end
  end

  // Result beat is the state as it stands after the tick.
  always_comb begin
    result.phase          = phase_reg_next;
    result.led_pattern    = led_reg_next;
    result.current_select = current_sel_reg_next;
    result.voltage_select = voltage_sel_reg_next;
    result.converter_on   = converter_reg_next;
  end

  // Output register and skid entry control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the result stage.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) out_data <= skid_data;
    end else if (accept) begin
      if (!out_valid || take) out_data <= result;
      else skid_data <= result;
    end
  end

  // A beat held in the skid entry always has one ahead of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with no result pending");

  // A beat accepted while the result stalls lands in the skid entry.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !out_ready) |=> skid_valid)
    else $error("beat lost while result stalled");

  // A stopped converter has both setpoints at zero.
  a_stop_selects: assert property (@(posedge clk) disable iff (rst)
    !converter_reg |-> (current_sel_reg == CUR_ZERO && voltage_sel_reg == VOL_ZERO))
    else $error("converter off with a live setpoint");

  // Fault is left only by a restart.
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase_reg == PH_FAULT && !(accept && in_data.restart)) |=> phase_reg == PH_FAULT)
    else $error("fault left without restart");

endmodule
`default_nettype wire

/* tb/battery_charge_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_sequencer_tb: self-checking bench for the charge sequencer
// Drives sample beats through the valid/ready input and predicts each status
// beat with a cycle-free model of the charge phases. Status beats are checked
// in order, field by field. The run covers directed corner cases, random
// charge cycles under several register settings, an output back-pressure
// stretch, and a closing charge cycle with no idling on either side.
// ----------------------------------------------------------------------------
module battery_charge_sequencer_tb;
  import bcs_pkg::*;

  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_OFF_CYCLES = 60;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Tracks the charge phase and holds the status beats still to come.
  class charge_scoreboard;
    logic [1:0] mode;
    logic [9:0] cutoff_v, full_i, stop_i, pres_i, top_v, pres_v;
    phase_t     ph;
    logic [15:0] timer;
    logic [9:0] min_i;
    logic [7:0] hold;
    logic [15:0] flat;
    logic [1:0] led, cur_sel, vol_sel;
    logic       conv;
    out_beat_t  expected_status[$];
    int         mismatches;

    function new();
      mode = 2'd0;
      cutoff_v = 10'd0;
      full_i = 10'd1023;
      stop_i = 10'd0;
      pres_i = 10'd0;
      top_v = 10'd0;
      pres_v = 10'd0;
      mismatches = 0;
      start_charge();
    endfunction

    // Initialization into precharge, as after reset or on a restart.
    function void start_charge();
      ph = PH_PRE;
      timer = PRECHARGE_TICKS;
      led = LED_SLOW;
      cur_sel = CUR_PRE;
      vol_sel = VOL_CHG;
      min_i = full_i & SENSE_MASK;
      hold = MIN_HOLD_TICKS;
      flat = FLAT_TICKS;
      conv = 1'b1;
    endfunction

    function void shut_down();
      vol_sel = VOL_ZERO;
      cur_sel = CUR_ZERO;
      conv = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [9:0] val);
      case (idx)
        REG_MODE:       mode = val[1:0];
        REG_CUTOFF_V:   cutoff_v = val;
        REG_FULL_I:     full_i = val;
        REG_STOP_I:     stop_i = val;
        REG_PRESENCE_I: pres_i = val;
        REG_TOPPING_V:  top_v = val;
        REG_PRESENCE_V: pres_v = val;
        default: ;
      endcase
    endfunction

    // Advance one tick for an accepted sample beat and queue its status.
    function void note_sample(in_beat_t b);
      logic [9:0] vs, is, ilim, pv;
      out_beat_t s;
      vs = b.battery_voltage & SENSE_MASK;
      is = b.charge_current & SENSE_MASK;
      ilim = full_i & SENSE_MASK;
      pv = pres_v & SENSE_MASK;
      if (b.restart) begin
        start_charge();
      end else begin
        case (ph)
          PH_PRE: begin
            led = LED_SLOW;
            if (vs < (cutoff_v & SENSE_MASK)) begin
              if (timer != 16'd0) timer = timer - 16'd1;
              else ph = PH_FAULT;
            end else begin
              ph = PH_CHARGE;
              cur_sel = CUR_FULL;
            end
          end
          PH_CHARGE: begin
            led = LED_SLOW;
            // Debounced minimum tracking while the converter regulates voltage.
            if (b.in_cv_regulation) begin
              if (is < min_i) begin
                if (hold != 8'd0) begin
                  hold = hold - 8'd1;
                end else begin
                  min_i = is;
                  hold = MIN_HOLD_TICKS;
                  flat = FLAT_TICKS;
                end
              end else begin
                hold = MIN_HOLD_TICKS;
                if (flat != 16'd0) flat = flat - 16'd1;
              end
            end else begin
              hold = MIN_HOLD_TICKS;
              flat = FLAT_TICKS;
              min_i = ilim;
            end
            if (min_i < (stop_i & SENSE_MASK) || flat == 16'd0) begin
              if (mode[0]) begin
                ph = PH_FLOAT;
                timer = FLOAT_TICKS;
                vol_sel = VOL_FLOAT;
              end else if (min_i < (pres_i & SENSE_MASK)) begin
                ph = PH_IDLE;
              end else begin
                ph = PH_DONE;
              end
            end
          end
          PH_FLOAT: begin
            led = LED_ON;
            if (timer != 16'd0) timer = timer - 16'd1;
            else ph = PH_DONE;
            if (mode[0] && timer < FLOAT_RELAX_TICKS && is < (pres_i & SENSE_MASK))
              ph = PH_IDLE;
          end
          PH_IDLE: begin
            led = LED_OFF;
            shut_down();
          end
          PH_FAULT: begin
            led = LED_FAST;
            shut_down();
          end
          PH_DONE: begin
            led = LED_ON;
            // Standby recharge when a still connected battery has sagged.
            if (mode[1]) begin
              if (vs < (top_v & SENSE_MASK) && vs > pv) begin
                ph = PH_CHARGE;
                cur_sel = CUR_FULL;
                vol_sel = VOL_CHG;
                min_i = ilim;
                hold = MIN_HOLD_TICKS;
                flat = FLAT_TICKS;
                conv = 1'b1;
              end else begin
                shut_down();
                if (vs < pv) ph = PH_IDLE;
              end
            end else begin
              ph = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      s.phase = ph;
      s.led_pattern = led;
      s.current_select = cur_sel;
      s.voltage_select = vol_sel;
      s.converter_on = conv;
      expected_status.push_back(s);
    endfunction

    // Compare one status beat with the oldest expected one.
    // Fields are listed as phase/LED/current select/voltage select/converter.
    function void check_status(out_beat_t got);
      out_beat_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: unexpected status beat: %0d/%0d/%0d/%0d/%0d",
                   $realtime, got.phase, got.led_pattern, got.current_select,
                   got.voltage_select, got.converter_on);
        return;
      end
      want = expected_status.pop_front();
      if (got.phase !== want.phase || got.led_pattern !== want.led_pattern ||
          got.current_select !== want.current_select ||
          got.voltage_select !== want.voltage_select ||
          got.converter_on !== want.converter_on) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: status mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                   $realtime, want.phase, want.led_pattern, want.current_select,
                   want.voltage_select, want.converter_on, got.phase, got.led_pattern,
                   got.current_select, got.voltage_select, got.converter_on);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cfg_write;
  logic [2:0] cfg_index;
  logic [9:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  charge_scoreboard sb;
  int idle_pct;
  int beats_sent;
  int cycles;
  bit hold_req;
  bit hold_done;

  battery_charge_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Status monitor: a beat moves when valid and ready meet at the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_status(out_data);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if ($urandom_range(1, 100) <= idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one sample beat, with an optional idle burst ahead of it.
  task automatic send_beat(in_beat_t b);
    @(negedge clk);
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(b);
    beats_sent++;
  endtask

  task automatic send_fields(logic [9:0] vs, logic [9:0] is, logic cv, logic rs);
    in_beat_t b;
    b.battery_voltage = vs;
    b.charge_current = is;
    b.in_cv_regulation = cv;
    b.restart = rs;
    send_beat(b);
  endtask

  task automatic pause_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every status beat to arrive, then a few more cycles.
  task automatic settle();
    while (sb.expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Program all registers; the unused index is written first and must be ignored.
  task automatic load_config(logic [1:0] m, logic [9:0] cut, logic [9:0] fi, logic [9:0] si,
                             logic [9:0] pi, logic [9:0] tv, logic [9:0] pv);
    logic [2:0] regs [8];
    logic [9:0] vals [8];
    regs = '{REG_UNUSED, REG_MODE, REG_CUTOFF_V, REG_FULL_I, REG_STOP_I,
             REG_PRESENCE_I, REG_TOPPING_V, REG_PRESENCE_V};
    vals = '{10'($urandom), 10'(m), cut, fi, si, pi, tv, pv};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(negedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [9:0] near_level(logic [9:0] lvl);
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd1023;
      2: return (lvl == 10'd0) ? 10'd0 : lvl - 10'd1;
      3: return lvl;
      4: return (lvl == 10'd1023) ? lvl : lvl + 10'd1;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic in_beat_t random_beat(int restart_pct);
    in_beat_t b;
    b.battery_voltage = 10'($urandom);
    b.charge_current = 10'($urandom);
    b.in_cv_regulation = 1'($urandom);
    b.restart = ($urandom_range(1, 100) <= restart_pct);
    return b;
  endfunction

  // One well-formed charge cycle with random content under the current settings.
  task automatic run_charge_cycle();
    in_beat_t b;
    b = random_beat(0);
    b.restart = 1'b1;
    send_beat(b);
    // Up to three samples under the cutoff, then one at or above it.
    repeat ($urandom_range(0, 3)) begin
      b = random_beat(0);
      b.battery_voltage = (sb.cutoff_v == 10'd0) ? 10'd0 : 10'($urandom_range(0, sb.cutoff_v - 1));
      send_beat(b);
    end
    b = random_beat(0);
    b.battery_voltage = 10'($urandom_range(sb.cutoff_v, 1023));
    send_beat(b);
    repeat ($urandom_range(0, 2)) begin
      b = random_beat(0);
      b.in_cv_regulation = 1'b0;
      send_beat(b);
    end
    // Tapering current in CV regulation, mostly under the stop current.
    repeat ($urandom_range(16, 22)) begin
      b = random_beat(0);
      b.in_cv_regulation = 1'b1;
      if (sb.stop_i != 10'd0 && $urandom_range(0, 3) != 0)
        b.charge_current = 10'($urandom_range(0, sb.stop_i - 1));
      send_beat(b);
    end
    // Float, done, standby and idle ticks around the voltage thresholds.
    repeat ($urandom_range(3, 10)) begin
      b = random_beat(3);
      b.battery_voltage = near_level($urandom_range(0, 1) ? sb.top_v : sb.pres_v);
      b.charge_current = near_level(sb.pres_i);
      send_beat(b);
    end
  endtask

  initial begin
    int phase_start;
    int pct_by_phase [6];
    logic [9:0] stop_pick, top_pick;
    pct_by_phase = '{20, 35, 15, 0, 40, 10};
    sb = new();
    idle_pct = 0;
    beats_sent = 0;
    cycles = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 10'd0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, precharge edge at the cutoff, CV taper into float.
    load_config(2'd3, 10'd512, 10'd1023, 10'd100, 10'd50, 10'd900, 10'd200);
    send_fields(10'd1023, 10'd1023, 1'b1, 1'b1);
    send_fields(10'd0, 10'd0, 1'b0, 1'b0);
    send_fields(10'd511, 10'd1023, 1'b1, 1'b0);
    send_fields(10'd512, 10'd0, 1'b0, 1'b0);
    send_fields(10'd1023, 10'd1023, 1'b0, 1'b0);
    repeat (17) send_fields(10'd1023, 10'd0, 1'b1, 1'b0);
    send_fields(10'd1023, 10'd1023, 1'b1, 1'b0);
    send_fields(10'd0, 10'd0, 1'b0, 1'b1);
    pause_input();
    settle();

    // Random charge cycles and noise under several settings, extremes first.
    for (int p = 0; p < 6; p++) begin
      idle_pct = pct_by_phase[p];
      case (p)
        0: load_config(2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        1: load_config(2'd3, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        default: begin
          stop_pick = 10'($urandom);
          top_pick = 10'($urandom_range(1, 1023));
          load_config(2'(p - 2), 10'($urandom), 10'($urandom_range(1, 1023)), stop_pick,
                      10'($urandom_range(0, stop_pick)), top_pick,
                      10'($urandom_range(0, top_pick)));
        end
      endcase
      phase_start = beats_sent;
      while (beats_sent - phase_start < 60) begin
        if (p == 2 && beats_sent - phase_start >= 20) hold_req = 1'b1;
        if ($urandom_range(0, 3) != 0) begin
          run_charge_cycle();
        end else begin
          repeat ($urandom_range(3, 12)) send_beat(random_beat(10));
        end
      end
      pause_input();
      settle();
    end

    // Closing charge cycle with no idling on either side.
    idle_pct = 0;
    run_charge_cycle();
    pause_input();
    settle();

    if (sb.mismatches == 0 && sb.expected_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bcs_pkg.sv
sv/battery_charge_sequencer.sv
tb/battery_charge_sequencer_tb.sv
